// File: hw/rtl/fkh_pkg.sv
// Shared types, constants and the bit-serial CRC32C reference function.
`default_nettype none

package fkh_pkg;

	localparam int ValueWidth = 44;
	localparam int HashWidth = 32;
	localparam int TotalWidth = 16;
	localparam int AddrWidth = 32;
	localparam logic [HashWidth-1:0] Crc32cPoly = 32'h82F6_3B78;

	typedef enum logic [1:0] {
		KIND_ADDR   = 2'd0,
		KIND_BUCKET = 2'd1,
		KIND_TOTAL  = 2'd2
	} fkh_kind_e;

	// Bit-serial reflected CRC, data taken from bit 0 upward. Used only at
	// elaboration to build the XOR matrices.
	function automatic logic [HashWidth-1:0] crc_bits(
		input logic [HashWidth-1:0] crc_in,
		input logic [63:0] data,
		input int nbits
	);
		logic [HashWidth-1:0] crc;
		logic fb;
		crc = crc_in;
		for (int k = 0; k < nbits; k++) begin
			fb = crc[0] ^ data[k];
			crc = (crc >> 1) ^ (fb ? Crc32cPoly : '0);
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fkh_crc_fold.sv
// One-step CRC32C fold of a data word into a running value as an XOR matrix.
`default_nettype none

module fkh_crc_fold
	import fkh_pkg::*;
#(
	parameter int DataWidth = 32
) (
	input  wire logic [HashWidth-1:0] crc_in,
	input  wire logic [DataWidth-1:0] data,
	output logic      [HashWidth-1:0] crc_out
);

	localparam int InWidth = HashWidth + DataWidth;

	typedef logic [InWidth-1:0][HashWidth-1:0] fkh_cols_t;

	// Column i is the fold result for a single set bit at input position i;
	// the low positions are the running value, the high ones the data.
	function automatic fkh_cols_t gen_cols();
		fkh_cols_t cols;
		logic [HashWidth-1:0] c;
		logic [63:0] d;
		for (int i = 0; i < InWidth; i++) begin
			c = '0;
			d = '0;
			if (i < HashWidth) begin
				c[i] = 1'b1;
			end else begin
				d[i-HashWidth] = 1'b1;
			end
			cols[i] = crc_bits(c, d, DataWidth);
		end
		return cols;
	endfunction

	localparam fkh_cols_t Cols = gen_cols();

	logic [InWidth-1:0] in_vec;

	assign in_vec = {data, crc_in};

	always_comb begin
		crc_out = '0;
		for (int i = 0; i < InWidth; i++) begin
			crc_out = crc_out ^ (in_vec[i] ? Cols[i] : '0);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/flow_key_crc32c_hash.sv
// A total request's hash passes the input stage and then the output register.
// Throughput: one request per cycle; the running CRC register and its fold
// matrix form the only loop, and only a total request waits on the output.
// Reset clears the running CRC to zero and empties the input and output stages.
`default_nettype none

module flow_key_crc32c_hash
	import fkh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // [43:0] value, [47:44] zero
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [31:0] hash
);

	logic                  valid_s1;
	fkh_kind_e             kind_s1;
	logic [ValueWidth-1:0] value_s1;
	logic [HashWidth-1:0]  crc_q;
	logic                  out_valid_q;
	logic [HashWidth-1:0]  out_hash_q;

	logic                  s_accept;
	logic                  advance;
	logic                  is_total;
	logic [HashWidth-1:0]  fold32_crc;
	logic [31:0]           fold32_data;
	logic [HashWidth-1:0]  fold32_out;
	logic [HashWidth-1:0]  fold64_out;

	assign is_total = (kind_s1 == KIND_TOTAL);
	assign advance = valid_s1 && (!is_total || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// An address request restarts the key from zero; a total is zero-extended.
	assign fold32_crc = (kind_s1 == KIND_ADDR) ? '0 : crc_q;
	assign fold32_data = (kind_s1 == KIND_ADDR) ? value_s1[AddrWidth-1:0]
		: {16'd0, value_s1[TotalWidth-1:0]};

	fkh_crc_fold #(.DataWidth(32)) u_fold32 (
		.crc_in (fold32_crc),
		.data   (fold32_data),
		.crc_out(fold32_out)
	);

	fkh_crc_fold #(.DataWidth(64)) u_fold64 (
		.crc_in (crc_q),
		.data   ({20'd0, value_s1}),
		.crc_out(fold64_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1 <= fkh_kind_e'(s_axis_tuser);
			value_s1 <= s_axis_tdata[ValueWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (advance) begin
			unique case (kind_s1)
				KIND_ADDR: begin
					crc_q <= fold32_out;
				end
				KIND_BUCKET: begin
					crc_q <= fold64_out;
				end
				KIND_TOTAL: begin
					crc_q <= fold32_out;
				end
				default: begin
					crc_q <= crc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_total) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_total) begin
			out_hash_q <= fold32_out;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_hash_q;

endmodule

`default_nettype wire
